/* src/asd_pkg.sv */
// asd_pkg: shared types and constants of the accelerometer step detector
// no dependencies; imported by every module of the block
package asd_pkg;

  localparam int unsigned AxisW   = 16;
  localparam int unsigned MagW    = 17;
  localparam int unsigned ThrW    = 17;
  localparam int unsigned IntvW   = 16;
  localparam int unsigned GainW   = 9;
  localparam int unsigned CountW  = 32;
  localparam int unsigned ClockW  = 32;
  localparam int unsigned DeltaW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 17;

  localparam logic [ThrW-1:0]  ThrReset  = ThrW'(1200);
  localparam logic [IntvW-1:0] IntvReset = IntvW'(280);
  localparam logic [GainW-1:0] GainReset = GainW'(8);
  // gain of one full unit, 256/256
  localparam logic [GainW-1:0] GainUnity = GainW'(256);

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_MIN_INTV  = 2'd1,
    REG_LP_GAIN   = 2'd2
  } cfg_reg_e;

  // item kinds
  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_TIME   = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [ThrW-1:0]  threshold;
    logic [IntvW-1:0] min_intv;
    logic [GainW-1:0] gain;
  } cfg_t;

  typedef struct packed {
    logic [MagW-1:0] lp_next;
    logic            hp_over;
  } filt_res_t;

endpackage

/* src/asd_cfg_regs.sv */
// asd_cfg_regs: configuration register file of the step detector
// depends on asd_pkg
module asd_cfg_regs
  import asd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgDatW-1:0] cfg_wdata_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  // decode write, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_THRESHOLD: cfg_d.threshold = cfg_wdata_i[ThrW-1:0];
        REG_MIN_INTV:  cfg_d.min_intv  = cfg_wdata_i[IntvW-1:0];
        REG_LP_GAIN:   cfg_d.gain      = cfg_wdata_i[GainW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= ThrReset;
      cfg_q.min_intv  <= IntvReset;
      cfg_q.gain      <= GainReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/asd_filter.sv */
// asd_filter: magnitude, low-pass update and high-pass threshold test
// depends on asd_pkg; purely combinational, one sample per cycle
module asd_filter
  import asd_pkg::*;
(
  input  logic signed [AxisW-1:0] accel_x_i,
  input  logic signed [AxisW-1:0] accel_y_i,
  input  logic signed [AxisW-1:0] accel_z_i,
  input  logic [MagW-1:0]         lp_i,
  input  cfg_t                    cfg_i,
  output filt_res_t               res_o
);

  logic [AxisW-1:0]        abs_x, abs_y, abs_z;
  logic [MagW-1:0]         mag;
  logic signed [MagW:0]    diff;
  logic [GainW-1:0]        gain_eff;
  logic signed [27:0]      diff_w, gain_w, prod, prod_adj, step_q, lp_sum;
  logic [MagW-1:0]         lp_new;
  logic signed [MagW+1:0]  hp, thr_w;

  // absolute values; the most negative sample maps to 32768 unsigned
  assign abs_x = accel_x_i[AxisW-1] ? AxisW'(-accel_x_i) : AxisW'(accel_x_i);
  assign abs_y = accel_y_i[AxisW-1] ? AxisW'(-accel_y_i) : AxisW'(accel_y_i);
  assign abs_z = accel_z_i[AxisW-1] ? AxisW'(-accel_z_i) : AxisW'(accel_z_i);
  assign mag   = MagW'(abs_x) + MagW'(abs_y) + MagW'(abs_z);

  // low-pass step: (mag - lp) * gain / 256, truncated toward zero
  assign diff     = $signed({1'b0, mag}) - $signed({1'b0, lp_i});
  assign gain_eff = (cfg_i.gain > GainUnity) ? GainUnity : cfg_i.gain;
  assign diff_w   = {{(28-MagW-1){diff[MagW]}}, diff};
  assign gain_w   = {{(28-GainW){1'b0}}, gain_eff};
  assign prod     = diff_w * gain_w;
  assign prod_adj = prod + (prod[27] ? 28'sd255 : 28'sd0);
  assign step_q   = prod_adj >>> 8;
  assign lp_sum   = $signed({{(28-MagW){1'b0}}, lp_i}) + step_q;
  assign lp_new   = lp_sum[MagW-1:0];

  // high-pass level against threshold, signed compare
  assign hp    = $signed({2'b00, mag}) - $signed({2'b00, lp_new});
  assign thr_w = $signed({2'b00, cfg_i.threshold});

  assign res_o.lp_next = lp_new;
  assign res_o.hp_over = (hp > thr_w);

endmodule

/* src/accel_step_detector_top.sv */
// accel_step_detector_top: step counter from 3-axis accelerometer words
// depends on asd_pkg, asd_cfg_regs and asd_filter
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one word per accepted
//   handshake: cmd_i = 0 is an acceleration sample (accel_*_i), cmd_i = 1
//   advances the millisecond clock by delta_ms_i.
//   Output channel (out_valid_o / out_ready_i) returns one word per input
//   word, in order: step_detected_o and the step count after that word.
//   Path: an accepted word sits in the input register, and its result is
//   registered in the result register once that register is free or
//   drains; out_valid_o then rises and the result can be taken.
//   Throughput: one word per cycle if not stalled; filter, threshold test
//   and state update all finish between the input and result registers.
//   Stall: while out_ready_i is low the result register holds, the input
//   register holds its word and in_ready_o drops once both are full.
//   Reset: rst_ni clears step count, low-pass level, last step time and
//   clock, and loads the default threshold, interval and gain.
//   Config port: write only while no word is in flight.
module accel_step_detector_top
  import asd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [CfgDatW-1:0]      cfg_wdata_i,
  // input words
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    cmd_i,
  input  logic signed [AxisW-1:0] accel_x_i,
  input  logic signed [AxisW-1:0] accel_y_i,
  input  logic signed [AxisW-1:0] accel_z_i,
  input  logic [DeltaW-1:0]       delta_ms_i,
  // result words
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    step_detected_o,
  output logic [CountW-1:0]       step_total_o
);

  cfg_t      cfg;
  filt_res_t filt;

  logic                    in_valid_q;
  logic                    cmd_q;
  logic signed [AxisW-1:0] ax_q, ay_q, az_q;
  logic [DeltaW-1:0]       delta_q;

  logic [CountW-1:0] count_q, count_d;
  logic [MagW-1:0]   lp_q, lp_d;
  logic [ClockW-1:0] last_q, last_d;
  logic [ClockW-1:0] clock_q, clock_d;

  logic              out_valid_q;
  logic              det_q, det_d;
  logic [CountW-1:0] total_q;

  logic advance;
  logic interval_ok;

  asd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  asd_filter u_filter (
    .accel_x_i (ax_q),
    .accel_y_i (ay_q),
    .accel_z_i (az_q),
    .lp_i      (lp_q),
    .cfg_i     (cfg),
    .res_o     (filt)
  );

  // handshake: word moves on when the result register is free or drains
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q   <= cmd_i;
      ax_q    <= accel_x_i;
      ay_q    <= accel_y_i;
      az_q    <= accel_z_i;
      delta_q <= delta_ms_i;
    end
  end

  // state update for the word in the input register
  assign interval_ok = (clock_q - last_q) > ClockW'(cfg.min_intv);

  always_comb begin
    count_d = count_q;
    lp_d    = lp_q;
    last_d  = last_q;
    clock_d = clock_q;
    det_d   = 1'b0;
    case (cmd_e'(cmd_q))
      CMD_TIME: begin
        clock_d = clock_q + ClockW'(delta_q);
      end
      CMD_SAMPLE: begin
        lp_d = filt.lp_next;
        if (filt.hp_over && interval_ok) begin
          det_d   = 1'b1;
          last_d  = clock_q;
          count_d = count_q + CountW'(1);
        end
      end
      default: begin
        det_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      lp_q    <= '0;
      last_q  <= '0;
      clock_q <= '0;
    end else if (advance) begin
      count_q <= count_d;
      lp_q    <= lp_d;
      last_q  <= last_d;
      clock_q <= clock_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      det_q   <= det_d;
      total_q <= count_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign step_detected_o = det_q;
  assign step_total_o    = total_q;

endmodule

/* sim/tb_accel_step_detector_top.sv */
// tb_accel_step_detector_top: self-checking testbench of the accelerometer step detector
// holds its own step predictor, random word traffic, idling phases and backpressure
// depends on asd_pkg and accel_step_detector_top
module tb_accel_step_detector_top;
  timeunit 1ns;
  timeprecision 1ps;

  import asd_pkg::*;

  // register index past the end of the list, writes to it are ignored
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;
  localparam logic signed [AxisW-1:0] AxisMin = 16'sh8000;
  localparam logic signed [AxisW-1:0] AxisMax = 16'sh7FFF;
  localparam longint LevelMax = 131071;

  typedef struct packed {
    logic              step;
    logic [CountW-1:0] total;
  } step_report_t;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  // block ports
  logic                    cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]      cfg_idx_i = '0;
  logic [CfgDatW-1:0]      cfg_wdata_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic                    cmd_i = 1'b0;
  logic signed [AxisW-1:0] accel_x_i = '0;
  logic signed [AxisW-1:0] accel_y_i = '0;
  logic signed [AxisW-1:0] accel_z_i = '0;
  logic [DeltaW-1:0]       delta_ms_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic                    step_detected_o;
  logic [CountW-1:0]       step_total_o;

  accel_step_detector_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .accel_x_i      (accel_x_i),
    .accel_y_i      (accel_y_i),
    .accel_z_i      (accel_z_i),
    .delta_ms_i     (delta_ms_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .step_detected_o(step_detected_o),
    .step_total_o   (step_total_o)
  );

  // predicted detector state, starts at the reset values
  logic [ThrW-1:0]   exp_thr = ThrReset;
  logic [IntvW-1:0]  exp_intv = IntvReset;
  logic [GainW-1:0]  exp_gain = GainReset;
  logic [CountW-1:0] exp_count = '0;
  logic [MagW-1:0]   exp_level = '0;
  logic [ClockW-1:0] exp_last_step = '0;
  logic [ClockW-1:0] exp_clock = '0;

  step_report_t expected_reports[$];

  // idling controls and run statistics
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int err_cnt = 0;
  int n_sample = 0;
  int n_time = 0;
  int n_reg_writes = 0;
  int n_checked = 0;
  int n_steps = 0;

  function automatic longint axis_abs(logic signed [AxisW-1:0] v);
    return (v < 0) ? -longint'(v) : longint'(v);
  endfunction

  // advance the predicted state by one word and return its report
  function automatic step_report_t predict_step_report(cmd_e cmd,
      logic signed [AxisW-1:0] ax, logic signed [AxisW-1:0] ay,
      logic signed [AxisW-1:0] az, logic [DeltaW-1:0] dt);
    step_report_t rep;
    longint mag;
    longint lvl;
    longint g;
    longint hp;
    logic [ClockW-1:0] since;
    rep.step = 1'b0;
    if (cmd == CMD_TIME) begin
      exp_clock = exp_clock + ClockW'(dt);
    end else begin
      mag = axis_abs(ax) + axis_abs(ay) + axis_abs(az);
      // gains above one full unit saturate
      g = (exp_gain > GainUnity) ? 256 : longint'(exp_gain);
      lvl = longint'(exp_level);
      lvl = lvl + ((mag - lvl) * g) / 256;
      if (lvl < 0) lvl = 0;
      if (lvl > LevelMax) lvl = LevelMax;
      exp_level = MagW'(lvl);
      hp = mag - lvl;
      since = exp_clock - exp_last_step;
      if (hp > longint'(exp_thr) && since > ClockW'(exp_intv)) begin
        exp_last_step = exp_clock;
        exp_count = exp_count + 1;
        rep.step = 1'b1;
      end
    end
    rep.total = exp_count;
    return rep;
  endfunction

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // result check against the oldest pending report
  always @(posedge clk_i) begin : result_check
    step_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected result word: step_detected %0d, step_total %0d",
               step_detected_o, step_total_o);
        err_cnt++;
      end else begin
        want = expected_reports.pop_front();
        n_checked++;
        if (step_detected_o) n_steps++;
        if (step_detected_o !== want.step) begin
          $error("step_detected: expected %0d, actual %0d", want.step, step_detected_o);
          err_cnt++;
        end
        if (step_total_o !== want.total) begin
          $error("step_total: expected %0d, actual %0d", want.total, step_total_o);
          err_cnt++;
        end
      end
    end
  end

  // offer one word, with random idle cycles ahead of it
  task automatic send_word(input cmd_e cmd, input logic signed [AxisW-1:0] ax,
      input logic signed [AxisW-1:0] ay, input logic signed [AxisW-1:0] az,
      input logic [DeltaW-1:0] dt);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    accel_x_i <= ax;
    accel_y_i <= ay;
    accel_z_i <= az;
    delta_ms_i <= dt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_reports.push_back(predict_step_report(cmd, ax, ay, az, dt));
    if (cmd == CMD_TIME) n_time++;
    else n_sample++;
    @(negedge clk_i);
  endtask

  // stop sending and wait for every pending result
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (expected_reports.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct, input int hold_cycles);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    hold_left = hold_cycles;
    @(negedge clk_i);
  endtask

  // register write, only called with nothing in flight
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_THRESHOLD: exp_thr = data[ThrW-1:0];
      REG_MIN_INTV:  exp_intv = data[IntvW-1:0];
      REG_LP_GAIN:   exp_gain = data[GainW-1:0];
      default: ;
    endcase
    n_reg_writes++;
    @(negedge clk_i);
  endtask

  task automatic apply_settings(input logic [CfgDatW-1:0] thr,
      input logic [CfgDatW-1:0] intv, input logic [CfgDatW-1:0] gain);
    wait_results_drained();
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_MIN_INTV, intv);
    write_reg(REG_LP_GAIN, gain);
  endtask

  task automatic randomize_config();
    logic [CfgDatW-1:0] thr;
    logic [CfgDatW-1:0] intv;
    logic [CfgDatW-1:0] gain;
    int roll;
    roll = $urandom_range(0, 99);
    thr = (roll < 70) ? CfgDatW'($urandom_range(0, 4000)) : CfgDatW'($urandom);
    roll = $urandom_range(0, 99);
    intv = (roll < 80) ? CfgDatW'($urandom_range(0, 600)) : CfgDatW'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 60) gain = CfgDatW'($urandom_range(0, 64));
    else if (roll < 80) gain = CfgDatW'($urandom_range(65, 256));
    else gain = CfgDatW'($urandom);
    apply_settings(thr, intv, gain);
  endtask

  // one axis: walking motion, strong peaks, full-range noise or extremes
  function automatic logic signed [AxisW-1:0] random_axis();
    int roll;
    int amp;
    roll = $urandom_range(0, 99);
    amp = $urandom_range(8000, 32767);
    if (roll < 40) return AxisW'($urandom_range(0, 6000) - 3000);
    if (roll < 55) return $urandom_range(0, 1) ? AxisW'(amp) : AxisW'(-amp);
    if (roll < 90) return AxisW'($urandom);
    case ($urandom_range(0, 3))
      0: return AxisMin;
      1: return AxisMax;
      2: return '0;
      default: return '1;
    endcase
  endfunction

  task automatic send_random_word();
    cmd_e cmd;
    logic [DeltaW-1:0] dt;
    int roll;
    roll = $urandom_range(0, 99);
    cmd = (roll < 35) ? CMD_TIME : CMD_SAMPLE;
    roll = $urandom_range(0, 99);
    if (roll < 70) dt = DeltaW'($urandom_range(0, 300));
    else if (roll < 90) dt = DeltaW'($urandom);
    else if (roll < 95) dt = '0;
    else dt = '1;
    send_word(cmd, random_axis(), random_axis(), random_axis(), dt);
  endtask

  // sample whose magnitude is exactly m, spread over negative axes
  task automatic send_mag(input longint m);
    longint rest;
    longint part[3];
    rest = m;
    for (int i = 0; i < 3; i++) begin
      part[i] = (rest > 32768) ? 32768 : rest;
      rest = rest - part[i];
    end
    send_word(CMD_SAMPLE, AxisW'(-part[0]), AxisW'(-part[1]), AxisW'(-part[2]), '0);
  endtask

  // field extremes, both word kinds and the interval edge at reset settings
  task automatic test_directed_cases();
    set_idling(0, 0, 0);
    send_word(CMD_SAMPLE, 0, 0, 0, 0);
    // largest magnitude before any time has passed
    send_word(CMD_SAMPLE, AxisMin, AxisMin, AxisMin, '1);
    // clock advance ignores the axes
    send_word(CMD_TIME, AxisMax, AxisMin, -1, '1);
    send_word(CMD_TIME, 0, 0, 0, 0);
    send_word(CMD_SAMPLE, AxisMax, AxisMax, AxisMax, 0);
    // second peak right after a step
    send_word(CMD_SAMPLE, AxisMin, AxisMax, -1, 0);
    send_word(CMD_TIME, 0, 0, 0, 281);
    // magnitude well under the low-pass level
    send_word(CMD_SAMPLE, 0, 0, 0, 0);
    send_word(CMD_SAMPLE, 1, -1, 1, '1);
    send_word(CMD_SAMPLE, AxisMax, AxisMin, 0, 0);
    // exactly the minimum interval, then one past it
    send_word(CMD_TIME, 0, 0, 0, 280);
    send_word(CMD_SAMPLE, AxisMin, AxisMin, AxisMin, 0);
    send_word(CMD_TIME, 0, 0, 0, 1);
    send_word(CMD_SAMPLE, AxisMin, AxisMin, AxisMin, 0);
    send_word(CMD_TIME, 0, 0, 0, 1000);
    send_word(CMD_SAMPLE, 16'sh5555, 16'shAAAA, 16'sh00FF, 16'hA5A5);
    send_word(CMD_SAMPLE, 100, 100, 100, 0);
    send_word(CMD_TIME, 16'sh1234, 16'sh4321, 16'shFFFE, 16'h5A5A);
  endtask

  // high-pass exactly at the threshold and one above, with the level frozen
  task automatic test_threshold_edge();
    apply_settings(CfgDatW'(500), CfgDatW'(0), CfgDatW'(0));
    set_idling(0, 0, 0);
    send_word(CMD_TIME, 0, 0, 0, 1);
    send_mag(longint'(exp_level) + 500);
    send_word(CMD_TIME, 0, 0, 0, 1);
    send_mag(longint'(exp_level) + 501);
  endtask

  // every register at its extremes, masking of wide data, spare index
  task automatic test_register_extremes();
    set_idling(12, 12, 0);
    apply_settings(CfgDatW'(0), CfgDatW'(0), CfgDatW'(0));
    repeat (25) send_random_word();
    apply_settings(CfgDatW'(131071), CfgDatW'(65535), CfgDatW'(256));
    repeat (25) send_random_word();
    apply_settings(CfgDatW'(1), CfgDatW'(1), CfgDatW'(1));
    repeat (25) send_random_word();
    apply_settings('1, '1, '1);
    repeat (25) send_random_word();
    apply_settings(CfgDatW'(1500), CfgDatW'(40), CfgDatW'(257));
    repeat (25) send_random_word();
    wait_results_drained();
    write_reg(RegSpare, CfgDatW'($urandom));
    repeat (25) send_random_word();
    apply_settings(CfgDatW'(ThrReset), CfgDatW'(IntvReset), CfgDatW'(GainReset));
    repeat (25) send_random_word();
  endtask

  // random traffic in each idling phase under random settings
  task automatic test_random_traffic();
    int send_mix[4] = '{0, 45, 0, 12};
    int recv_mix[4] = '{0, 0, 45, 12};
    for (int p = 0; p < 4; p++) begin
      for (int c = 0; c < 2; c++) begin
        randomize_config();
        set_idling(send_mix[p], recv_mix[p], 0);
        repeat (175) send_random_word();
      end
    end
  endtask

  // long receiver hold-off that fills the block, then a full drain
  task automatic test_backpressure();
    randomize_config();
    set_idling(0, 45, 80);
    repeat (24) send_random_word();
    wait_results_drained();
    repeat (16) send_random_word();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_cases();
    test_threshold_edge();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();
    wait_results_drained();
    repeat (10) @(negedge clk_i);
    $display("covered %0d words (%0d samples, %0d clock advances), %0d register writes",
             n_sample + n_time, n_sample, n_time, n_reg_writes);
    $display("checked %0d results, %0d of them counted a step", n_checked, n_steps);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* files.f */
src/asd_pkg.sv
src/asd_cfg_regs.sv
src/asd_filter.sv
src/accel_step_detector_top.sv
sim/tb_accel_step_detector_top.sv
